// ----- rtl/gcm_pkg.sv -----
// Shared constants, codes and types of the gray co-occurrence matrix block.
package gcm_pkg;

  localparam int MAX_LEVELS      = 16;
  localparam int LEVEL_BITS      = $clog2(MAX_LEVELS);
  localparam int LEVELS_CFG_BITS = 5;
  localparam int MAX_WIDTH       = 1024;
  localparam int WIDTH_BITS      = 11;
  localparam int COL_BITS        = 10;
  localparam int MAX_OFFSET      = 4;
  localparam int ROW_BITS        = 3;
  localparam int OFFX_BITS       = 4;
  localparam int COUNT_BITS      = 22;
  localparam int PIXEL_BITS      = 8;
  localparam int CFG_DATA_BITS   = 11;
  localparam int CFG_INDEX_BITS  = 2;

  localparam int DELAY_DEPTH     = MAX_OFFSET * (MAX_WIDTH + 1);
  localparam int DELAY_ADDR_BITS = $clog2(DELAY_DEPTH);
  localparam int DIST_BITS       = DELAY_ADDR_BITS + 2;
  localparam int XREL_BITS       = WIDTH_BITS + 1;
  localparam int SPAN_BITS       = ROW_BITS + WIDTH_BITS;
  localparam int QPROD_BITS      = PIXEL_BITS + LEVELS_CFG_BITS;

  localparam int BIN_ENTRIES     = MAX_LEVELS * MAX_LEVELS;
  localparam int BIN_ADDR_BITS   = 2 * LEVEL_BITS;

  localparam int RESULT_DEPTH    = 8;
  localparam int RES_PTR_BITS    = $clog2(RESULT_DEPTH);
  localparam int RES_CNT_BITS    = RES_PTR_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVELS   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_X = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_Y = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH    = 2'd3;

  localparam logic [LEVELS_CFG_BITS-1:0] LEVELS_RESET   = 5'd4;
  localparam logic [OFFX_BITS-1:0]       OFFSET_X_RESET = 4'd1;
  localparam logic [ROW_BITS-1:0]        OFFSET_Y_RESET = 3'd0;
  localparam logic [WIDTH_BITS-1:0]      WIDTH_RESET    = 11'd1024;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  saturated;
  } result_t;

endpackage

// ----- rtl/gray_cooccurrence_matrix.sv -----
// Symmetric gray-level co-occurrence matrix over a raster pixel stream.
// Throughput: one item per cycle while in_stall is low; pixel, read and clear items
// may follow back to back. A read result enters the queue from the last stage below.
// The three stages are input register, delay line read, and count read-modify-write.
// Results wait in an 8-entry queue; input stalls when queue plus reads in flight fill it.
// Synchronous reset clears positions, valid bits and queue at once; no clearing pass.
module gray_cooccurrence_matrix import gcm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                op,
  input  logic [PIXEL_BITS-1:0]     pixel,
  input  logic                      frame_start,
  input  logic [LEVEL_BITS-1:0]     row_bin,
  input  logic [LEVEL_BITS-1:0]     col_bin,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COUNT_BITS-1:0]     bin_count,
  output logic                      saturated
);

  logic [LEVELS_CFG_BITS-1:0] levels;
  logic signed [OFFX_BITS-1:0] offset_x;
  logic [ROW_BITS-1:0]        offset_y;
  logic [WIDTH_BITS-1:0]      image_width;

  logic                       s0_valid;
  logic [1:0]                 s0_op;
  logic [PIXEL_BITS-1:0]      s0_pixel;
  logic                       s0_start;
  logic [LEVEL_BITS-1:0]      s0_row_bin;
  logic [LEVEL_BITS-1:0]      s0_col_bin;

  logic [COL_BITS-1:0]        column_position;
  logic [ROW_BITS-1:0]        row_position;
  logic [DELAY_ADDR_BITS-1:0] delay_ptr;
  logic                       delay_filled;

  logic                       s1_valid;
  logic [1:0]                 s1_op;
  logic [LEVEL_BITS-1:0]      s1_a;
  logic [LEVEL_BITS-1:0]      s1_col_bin;
  logic                       s1_pair_ok;
  logic                       s1_self;
  logic                       s1_fill_ok;

  logic                       s2_valid;
  logic [1:0]                 s2_op;
  logic [BIN_ADDR_BITS-1:0]   s2_addr;
  logic [1:0]                 s2_inc;

  logic [BIN_ENTRIES-1:0]     bin_valid;
  logic                       fwd_valid;
  logic [BIN_ADDR_BITS-1:0]   fwd_addr;
  logic [COUNT_BITS-1:0]      fwd_data;

  logic [LEVELS_CFG_BITS-1:0] lv_eff;
  logic [WIDTH_BITS-1:0]      w_eff;
  logic signed [OFFX_BITS-1:0] dx_eff;
  logic [ROW_BITS-1:0]        dy_eff;

  logic                       accept;
  logic                       pix_go;
  logic [QPROD_BITS-1:0]      q_prod;
  logic [LEVEL_BITS-1:0]      q;
  logic [COL_BITS-1:0]        col_cur;
  logic [ROW_BITS-1:0]        row_cur;
  logic signed [XREL_BITS-1:0] x_rel;
  logic                       pair_ok;
  logic [SPAN_BITS-1:0]       span;
  logic signed [DIST_BITS-1:0] pair_dist;
  logic signed [DIST_BITS-1:0] back;
  logic signed [DIST_BITS-1:0] back_wrap;
  logic [DELAY_ADDR_BITS-1:0] delay_raddr;
  logic [LEVEL_BITS-1:0]      delay_rdata;
  logic                       self_pair;
  logic                       fill_ok;
  logic [WIDTH_BITS-1:0]      col_step;

  logic [LEVEL_BITS-1:0]      p;
  logic [LEVEL_BITS-1:0]      b_sel;
  logic [LEVEL_BITS-1:0]      lo;
  logic [LEVEL_BITS-1:0]      hi;
  logic [BIN_ADDR_BITS-1:0]   count_raddr;
  logic [COUNT_BITS-1:0]      count_rdata;

  logic [COUNT_BITS-1:0]      cur;
  logic [COUNT_BITS:0]        sum;
  logic [COUNT_BITS-1:0]      count_new;
  logic                       count_we;
  logic                       res_push;
  result_t                    res_in;
  result_t                    res_head;
  logic [RES_CNT_BITS-1:0]    res_count;
  logic [1:0]                 reads_in_flight;
  logic [RES_CNT_BITS:0]      credit_used;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      levels      <= LEVELS_RESET;
      offset_x    <= OFFSET_X_RESET;
      offset_y    <= OFFSET_Y_RESET;
      image_width <= WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVELS:   levels      <= cfg_data[LEVELS_CFG_BITS-1:0];
        CFG_OFFSET_X: offset_x    <= $signed(cfg_data[OFFX_BITS-1:0]);
        CFG_OFFSET_Y: offset_y    <= cfg_data[ROW_BITS-1:0];
        CFG_WIDTH:    image_width <= cfg_data[WIDTH_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    lv_eff = levels;
    if (levels == '0) begin
      lv_eff = LEVELS_CFG_BITS'(1);
    end else if (levels > LEVELS_CFG_BITS'(MAX_LEVELS)) begin
      lv_eff = LEVELS_CFG_BITS'(MAX_LEVELS);
    end
    w_eff = image_width;
    if (image_width == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (image_width > WIDTH_BITS'(MAX_WIDTH)) begin
      w_eff = WIDTH_BITS'(MAX_WIDTH);
    end
    dx_eff = offset_x;
    if (offset_x > $signed(OFFX_BITS'(MAX_OFFSET))) begin
      dx_eff = $signed(OFFX_BITS'(MAX_OFFSET));
    end else if (offset_x < -$signed(OFFX_BITS'(MAX_OFFSET))) begin
      dx_eff = -$signed(OFFX_BITS'(MAX_OFFSET));
    end
    dy_eff = (offset_y > ROW_BITS'(MAX_OFFSET)) ? ROW_BITS'(MAX_OFFSET) : offset_y;
    if (dy_eff == '0 && dx_eff < 0) begin
      dx_eff = -dx_eff;
    end
  end

  assign reads_in_flight = 2'(s0_valid && s0_op == OP_READ)
                         + 2'(s1_valid && s1_op == OP_READ)
                         + 2'(s2_valid && s2_op == OP_READ);
  assign credit_used = {1'b0, res_count} + (RES_CNT_BITS + 1)'(reads_in_flight);
  assign in_stall    = credit_used >= (RES_CNT_BITS + 1)'(RESULT_DEPTH);
  assign accept      = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_op      <= op;
      s0_pixel   <= pixel;
      s0_start   <= frame_start;
      s0_row_bin <= row_bin;
      s0_col_bin <= col_bin;
    end
  end

  // quantize, locate partner, address delay line
  always_comb begin
    pix_go    = s0_valid && s0_op == OP_PIXEL;
    q_prod    = {{LEVELS_CFG_BITS{1'b0}}, s0_pixel} * {{PIXEL_BITS{1'b0}}, lv_eff};
    q         = q_prod[PIXEL_BITS +: LEVEL_BITS];
    col_cur   = s0_start ? '0 : column_position;
    row_cur   = s0_start ? '0 : row_position;
    x_rel     = $signed({{(XREL_BITS - COL_BITS){1'b0}}, col_cur})
              - $signed({{(XREL_BITS - OFFX_BITS){dx_eff[OFFX_BITS-1]}}, dx_eff});
    pair_ok   = (row_cur >= dy_eff) && !x_rel[XREL_BITS-1]
              && (x_rel[WIDTH_BITS-1:0] < w_eff);
    span      = {{WIDTH_BITS{1'b0}}, dy_eff} * {{ROW_BITS{1'b0}}, w_eff};
    pair_dist = $signed({{(DIST_BITS - SPAN_BITS){1'b0}}, span})
              + $signed({{(DIST_BITS - OFFX_BITS){dx_eff[OFFX_BITS-1]}}, dx_eff});
    back      = $signed({2'b00, delay_ptr}) - pair_dist;
    back_wrap = back + $signed(DIST_BITS'(DELAY_DEPTH));
    delay_raddr = back[DIST_BITS-1] ? back_wrap[DELAY_ADDR_BITS-1:0]
                                    : back[DELAY_ADDR_BITS-1:0];
    self_pair = pair_dist[DIST_BITS-1] || pair_dist == '0;
    fill_ok   = delay_filled || !back[DIST_BITS-1];
    col_step  = {1'b0, col_cur} + WIDTH_BITS'(1);
  end

  gcm_ram #(
    .WIDTH (LEVEL_BITS),
    .DEPTH (DELAY_DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (pix_go),
    .waddr (delay_ptr),
    .wdata (q),
    .raddr (delay_raddr),
    .rdata (delay_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      delay_ptr       <= '0;
      delay_filled    <= 1'b0;
    end else if (pix_go) begin
      if (col_step >= w_eff) begin
        column_position <= '0;
        row_position    <= (row_cur < ROW_BITS'(MAX_OFFSET)) ? row_cur + 1'b1 : row_cur;
      end else begin
        column_position <= col_step[COL_BITS-1:0];
        row_position    <= row_cur;
      end
      if (delay_ptr == DELAY_ADDR_BITS'(DELAY_DEPTH - 1)) begin
        delay_ptr    <= '0;
        delay_filled <= 1'b1;
      end else begin
        delay_ptr <= delay_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_op      <= s0_op;
    s1_a       <= (s0_op == OP_READ) ? s0_row_bin : q;
    s1_col_bin <= s0_col_bin;
    s1_pair_ok <= pair_ok;
    s1_self    <= self_pair;
    s1_fill_ok <= fill_ok;
  end

  // pick partner, address the symmetric count entry
  always_comb begin
    p           = s1_self ? s1_a : (s1_fill_ok ? delay_rdata : '0);
    b_sel       = (s1_op == OP_READ) ? s1_col_bin : p;
    lo          = (s1_a < b_sel) ? s1_a : b_sel;
    hi          = (s1_a < b_sel) ? b_sel : s1_a;
    count_raddr = {lo, hi};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && (s1_op != OP_PIXEL || s1_pair_ok);
    end
  end

  always_ff @(posedge clk) begin
    s2_op   <= s1_op;
    s2_addr <= count_raddr;
    s2_inc  <= (s1_a == b_sel) ? 2'd2 : 2'd1;
  end

  gcm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_ENTRIES)
  ) u_count_ram (
    .clk   (clk),
    .we    (count_we),
    .waddr (s2_addr),
    .wdata (count_new),
    .raddr (count_raddr),
    .rdata (count_rdata)
  );

  // read-modify-write with bypass of the previous write
  always_comb begin
    if (fwd_valid && fwd_addr == s2_addr) begin
      cur = fwd_data;
    end else if (bin_valid[s2_addr]) begin
      cur = count_rdata;
    end else begin
      cur = '0;
    end
    sum       = {1'b0, cur} + (COUNT_BITS + 1)'(s2_inc);
    count_new = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
    count_we  = s2_valid && s2_op == OP_PIXEL;
    res_push  = s2_valid && s2_op == OP_READ;
    res_in.count     = cur;
    res_in.saturated = (cur == COUNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (s2_valid && s2_op == OP_CLEAR) begin
      bin_valid <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= count_we;
      if (count_we) begin
        bin_valid[s2_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (count_we) begin
      fwd_addr <= s2_addr;
      fwd_data <= count_new;
    end
  end

  gcm_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (res_head),
    .count     (res_count)
  );

  assign bin_count = res_head.count;
  assign saturated = res_head.saturated;

`ifndef SYNTHESIS
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_READ) |-> ##4 out_valid)
    else $error("read transfer gave no result in time");

  a_clear_bins: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_op == OP_CLEAR) |=> (bin_valid == '0))
    else $error("clear left valid bins");

  a_ptr_advance: assert property (@(posedge clk) disable iff (rst)
    pix_go |=> (delay_ptr != $past(delay_ptr)))
    else $error("delay pointer did not advance on a pixel");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_count == RES_CNT_BITS'(RESULT_DEPTH)) |-> (out_valid && !out_stall))
    else $error("result queue overflow");
`endif

endmodule

// ----- rtl/gcm_ram.sv -----
// Generic single write port RAM with one registered read port.
module gcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gcm_res_fifo.sv -----
// Result queue between the count pipeline and the output channel.
module gcm_res_fifo import gcm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  result_t                 push_data,
  input  logic                    out_stall,
  output logic                    out_valid,
  output result_t                 head,
  output logic [RES_CNT_BITS-1:0] count
);

  result_t                 entries [RESULT_DEPTH];
  logic [RES_PTR_BITS-1:0] wr_ptr;
  logic [RES_PTR_BITS-1:0] rd_ptr;
  logic                    pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the gray co-occurrence matrix: pixel, read and clear transfers.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT        = 11;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 6;
  localparam int RANDOM_ITEMS    = 1600;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic [1:0]            op;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_start;
    logic [LEVEL_BITS-1:0] row_bin;
    logic [LEVEL_BITS-1:0] col_bin;
  } gcm_item_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                op = OP_PIXEL;
  logic [PIXEL_BITS-1:0]     pixel = '0;
  logic                      frame_start = 1'b0;
  logic [LEVEL_BITS-1:0]     row_bin = '0;
  logic [LEVEL_BITS-1:0]     col_bin = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [COUNT_BITS-1:0]     bin_count;
  logic                      saturated;

  // matrix predictor state and its copy of the registers
  logic [COUNT_BITS-1:0]       glcm_counts [BIN_ENTRIES];
  logic [LEVEL_BITS-1:0]       level_history [DELAY_DEPTH];
  int                          hist_wr_ptr;
  int                          col_pos;
  int                          row_pos;
  logic [LEVELS_CFG_BITS-1:0]  cur_levels = LEVELS_RESET;
  logic signed [OFFX_BITS-1:0] cur_offset_x = OFFSET_X_RESET;
  logic [ROW_BITS-1:0]         cur_offset_y = OFFSET_Y_RESET;
  logic [WIDTH_BITS-1:0]       cur_width = WIDTH_RESET;

  result_t   expected_reads [$];
  gcm_item_t pending_items [$];
  gcm_item_t offered;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        hold_cycles = 0;
  bit        steady = 1'b0;
  bit        hold_armed = 1'b0;

  gray_cooccurrence_matrix dut (.*);

  always #2ns clk = ~clk;

  function automatic int eff_levels();
    if (cur_levels == 0) return 1;
    if (cur_levels > MAX_LEVELS) return MAX_LEVELS;
    return cur_levels;
  endfunction

  function automatic int eff_width();
    if (cur_width == 0) return 1;
    if (cur_width > MAX_WIDTH) return MAX_WIDTH;
    return cur_width;
  endfunction

  function automatic int eff_dy();
    return (cur_offset_y > MAX_OFFSET) ? MAX_OFFSET : cur_offset_y;
  endfunction

  function automatic void clear_counts();
    foreach (glcm_counts[i]) glcm_counts[i] = '0;
  endfunction

  function automatic void bump_count(input int a, input int b);
    if (glcm_counts[a * MAX_LEVELS + b] != COUNT_MAX)
      glcm_counts[a * MAX_LEVELS + b] = glcm_counts[a * MAX_LEVELS + b] + 1'b1;
  endfunction

  function automatic void accumulate_pixel(input logic [PIXEL_BITS-1:0] pix, input logic start);
    int w, dx, dy, pair_dist;
    logic [LEVEL_BITS-1:0] q, partner;
    w = eff_width();
    dy = eff_dy();
    dx = cur_offset_x;
    if (dx > MAX_OFFSET) dx = MAX_OFFSET;
    if (dx < -MAX_OFFSET) dx = -MAX_OFFSET;
    if (dy == 0 && dx < 0) dx = -dx;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    q = LEVEL_BITS'((int'(pix) * eff_levels()) >> 8);
    if (row_pos >= dy && col_pos - dx >= 0 && col_pos - dx < w) begin
      pair_dist = dy * w + dx;
      if (pair_dist <= 0) partner = q;
      else partner = level_history[(hist_wr_ptr + DELAY_DEPTH - pair_dist) % DELAY_DEPTH];
      bump_count(int'(q), int'(partner));
      bump_count(int'(partner), int'(q));
    end
    level_history[hist_wr_ptr] = q;
    hist_wr_ptr = (hist_wr_ptr + 1) % DELAY_DEPTH;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos < MAX_OFFSET) row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic void predict_item(input gcm_item_t it);
    result_t r;
    case (it.op)
      OP_PIXEL: accumulate_pixel(it.pixel, it.frame_start);
      OP_READ: begin
        r.count = glcm_counts[it.row_bin * MAX_LEVELS + it.col_bin];
        r.saturated = (r.count == COUNT_MAX);
        expected_reads.push_back(r);
      end
      OP_CLEAR: clear_counts();
      default: ;
    endcase
  endfunction

  function automatic void queue_item(input logic [1:0] code, input logic [PIXEL_BITS-1:0] pix,
                                     input logic fs, input logic [LEVEL_BITS-1:0] r,
                                     input logic [LEVEL_BITS-1:0] c);
    gcm_item_t it;
    it.op = code;
    it.pixel = pix;
    it.frame_start = fs;
    it.row_bin = r;
    it.col_bin = c;
    pending_items.push_back(it);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: read-back mismatch: %s", $realtime, what);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      CFG_LEVELS:   cur_levels = value[LEVELS_CFG_BITS-1:0];
      CFG_OFFSET_X: cur_offset_x = value[OFFX_BITS-1:0];
      CFG_OFFSET_Y: cur_offset_y = value[ROW_BITS-1:0];
      CFG_WIDTH:    cur_width = value[WIDTH_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // wait for all transfers and read-backs, then let pixel updates retire
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_reads.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_item(offered);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered = pending_items.pop_front();
          in_valid <= 1'b1;
          op <= offered.op;
          pixel <= offered.pixel;
          frame_start <= offered.frame_start;
          row_bin <= offered.row_bin;
          col_bin <= offered.col_bin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          report_mismatch("result transfer with no read outstanding");
        end else begin
          want = expected_reads.pop_front();
          if (bin_count !== want.count)
            report_mismatch($sformatf("bin_count %0d, expected %0d", bin_count, want.count));
          if (saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b", saturated, want.saturated));
        end
      end
      if (hold_armed && hold_cycles < HOLD_OFF_CYCLES) begin
        out_stall <= 1'b1;
        hold_cycles++;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n_items, random_count, phase, frame_left, read_pct, roll, lv, w;
    clear_counts();
    foreach (level_history[i]) level_history[i] = '0;
    hist_wr_ptr = 0;
    col_pos = 0;
    row_pos = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // power-on settings: pixel extremes, ignored codes and frame starts, clear
    queue_item(OP_PIXEL, 8'd0, 1'b1, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd255, 1'b0, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd255, 1'b0, 4'd0, 4'd0);
    queue_item(OP_READ, 8'd0, 1'b0, 4'd0, 4'd3);
    queue_item(OP_READ, 8'd0, 1'b0, 4'd3, 4'd3);
    queue_item(OP_UNUSED, 8'd255, 1'b1, 4'd15, 4'd15);
    queue_item(OP_READ, 8'd0, 1'b1, 4'd3, 4'd0);
    queue_item(OP_CLEAR, 8'd0, 1'b1, 4'd0, 4'd0);
    queue_item(OP_READ, 8'd0, 1'b0, 4'd3, 4'd3);
    settle();

    // levels above range, offset_y above range, width zero
    write_reg(CFG_LEVELS, 11'd31);
    write_reg(CFG_OFFSET_X, 11'd0);
    write_reg(CFG_OFFSET_Y, 11'd7);
    write_reg(CFG_WIDTH, 11'd0);
    queue_item(OP_PIXEL, 8'd255, 1'b1, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd16, 1'b0, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd0, 1'b0, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd255, 1'b0, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd255, 1'b0, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd255, 1'b0, 4'd0, 4'd0);
    queue_item(OP_READ, 8'd0, 1'b0, 4'd15, 4'd15);
    queue_item(OP_READ, 8'd0, 1'b0, 4'd1, 4'd15);
    settle();

    // levels zero, offset_x below range, width above range
    write_reg(CFG_LEVELS, 11'd0);
    write_reg(CFG_OFFSET_X, 11'd8);
    write_reg(CFG_OFFSET_Y, 11'd0);
    write_reg(CFG_WIDTH, 11'd2047);
    queue_item(OP_PIXEL, 8'd255, 1'b1, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd7, 1'b0, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd128, 1'b0, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd200, 1'b0, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd255, 1'b0, 4'd0, 4'd0);
    queue_item(OP_READ, 8'd0, 1'b0, 4'd0, 4'd0);
    settle();

    // shrink the width while the column sits beyond it
    write_reg(CFG_WIDTH, 11'd3);
    queue_item(OP_PIXEL, 8'd90, 1'b0, 4'd0, 4'd0);
    queue_item(OP_PIXEL, 8'd30, 1'b0, 4'd0, 4'd0);
    queue_item(OP_READ, 8'd0, 1'b0, 4'd0, 4'd0);

    random_count = 0;
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 5))
        0:       roll = 0;
        1:       roll = 1;
        2:       roll = MAX_LEVELS;
        3:       roll = 31;
        default: roll = $urandom_range(2, MAX_LEVELS);
      endcase
      write_reg(CFG_LEVELS, CFG_DATA_BITS'(roll));
      write_reg(CFG_OFFSET_X, CFG_DATA_BITS'($urandom_range(0, 15)));
      roll = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
      write_reg(CFG_OFFSET_Y, CFG_DATA_BITS'(roll));
      if (phase == 4) begin
        roll = $urandom_range(MAX_WIDTH, 2047);
      end else begin
        case ($urandom_range(0, 7))
          0:       roll = 0;
          1:       roll = 1;
          2:       roll = $urandom_range(17, 48);
          default: roll = $urandom_range(2, 16);
        endcase
      end
      write_reg(CFG_WIDTH, CFG_DATA_BITS'(roll));

      steady = (phase == 1);
      if (phase == 3) hold_armed = 1'b1;
      read_pct = (phase == 3) ? 50 : 20;
      lv = eff_levels();
      w = eff_width();
      frame_left = ($urandom_range(0, 1) == 0) ? 0 : w;
      n_items = $urandom_range(50, 120);
      repeat (n_items) begin
        roll = $urandom_range(0, 99);
        if (roll < read_pct) begin
          queue_item(OP_READ, PIXEL_BITS'($urandom), 1'($urandom),
                     LEVEL_BITS'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(0, lv - 1)),
                     LEVEL_BITS'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(0, lv - 1)));
        end else if (roll < read_pct + 3) begin
          queue_item(OP_CLEAR, PIXEL_BITS'($urandom), 1'($urandom),
                     LEVEL_BITS'($urandom), LEVEL_BITS'($urandom));
        end else if (roll < read_pct + 5) begin
          queue_item(OP_UNUSED, PIXEL_BITS'($urandom), 1'($urandom),
                     LEVEL_BITS'($urandom), LEVEL_BITS'($urandom));
        end else if (roll < read_pct + 8) begin
          queue_item(OP_PIXEL, PIXEL_BITS'($urandom), 1'($urandom),
                     LEVEL_BITS'($urandom), LEVEL_BITS'($urandom));
        end else begin
          queue_item(OP_PIXEL, PIXEL_BITS'($urandom), frame_left == 0,
                     LEVEL_BITS'($urandom), LEVEL_BITS'($urandom));
          if (frame_left == 0)
            frame_left = w * $urandom_range(eff_dy() + 1, eff_dy() + 3) - 1;
          else
            frame_left--;
        end
      end
      random_count += n_items;
      phase++;
    end

    settle();
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
